// ===== rtl/omni_drive_pd_mixer_macros.svh =====
// Assertion macros shared by the omni drive mixer RTL
`ifndef OMNI_DRIVE_PD_MIXER_MACROS_SVH
`define OMNI_DRIVE_PD_MIXER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define OMD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("omd assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define OMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("omd assertion failed");

`endif

// ===== rtl/omd_pkg.sv =====
// Types, constants and the sine table of the omni drive mixer
`default_nettype none

package omd_pkg;

  // Sine table geometry
  localparam int SINE_TABLE_BITS = 8;
  localparam int TAB_N           = 1 << SINE_TABLE_BITS;
  localparam int TAB_ADDR_W      = SINE_TABLE_BITS + 1;
  localparam int WHEEL_COUNT     = 3;
  localparam logic [1:0] WHEEL_LAST = 2'(WHEEL_COUNT - 1);

  // Port widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 10;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Scale of the integer wheel value
  localparam logic signed [25:0] POWER_SCALE = 26'sd2390;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Taylor series divisors (2k)(2k+1) and their reciprocals 2^64 / d
  localparam logic [63:0] TAYLOR_D1 = 64'd6;
  localparam logic [63:0] TAYLOR_D2 = 64'd20;
  localparam logic [63:0] TAYLOR_D3 = 64'd42;
  localparam logic [63:0] TAYLOR_D4 = 64'd72;
  localparam logic [63:0] TAYLOR_D5 = 64'd110;
  localparam logic [63:0] TAYLOR_D6 = 64'd156;
  localparam logic [63:0] TAYLOR_D7 = 64'd210;
  localparam logic [63:0] TAYLOR_R1 = 64'((65'd1 << 64) / 65'd6);
  localparam logic [63:0] TAYLOR_R2 = 64'((65'd1 << 64) / 65'd20);
  localparam logic [63:0] TAYLOR_R3 = 64'((65'd1 << 64) / 65'd42);
  localparam logic [63:0] TAYLOR_R4 = 64'((65'd1 << 64) / 65'd72);
  localparam logic [63:0] TAYLOR_R5 = 64'((65'd1 << 64) / 65'd110);
  localparam logic [63:0] TAYLOR_R6 = 64'((65'd1 << 64) / 65'd156);
  localparam logic [63:0] TAYLOR_R7 = 64'((65'd1 << 64) / 65'd210);

  typedef enum logic [7:0] {
    CMD_STOP = 8'h81,
    CMD_RUN  = 8'hA2
  } cmd_code_e;

  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_DERIV_GAIN  = 3'd1,
    REG_SPEED_CLAMP = 3'd2,
    REG_TURN_CLAMP  = 3'd3,
    REG_WHEEL0_ID   = 3'd4,
    REG_WHEEL1_ID   = 3'd5,
    REG_WHEEL2_ID   = 3'd6,
    REG_NONE        = 3'd7
  } reg_idx_e;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PD_MUL = 7'b0000010,
    ST_PD_SUM = 7'b0000100,
    ST_SCALE  = 7'b0001000,
    ST_W_MUL  = 7'b0010000,
    ST_W_SUM  = 7'b0100000,
    ST_W_EMIT = 7'b1000000
  } state_e;

  typedef struct packed {
    logic signed [15:0] prop_gain;
    logic signed [15:0] deriv_gain;
    logic [11:0]        speed_clamp;
    logic [11:0]        turn_clamp;
    logic [10:0]        wheel0_id;
    logic [10:0]        wheel1_id;
    logic [10:0]        wheel2_id;
  } cfg_t;

  // Controller to datapath strobes
  typedef struct packed {
    logic       load;
    logic       pd_mul;
    logic       pd_sum;
    logic       scale;
    logic       w_mul;
    logic       w_sum;
    logic       emit;
    logic       stop;
    logic [1:0] wheel;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // Mounting phase of each wheel, 65536 per turn
  function automatic logic [15:0] wheel_phase(input logic [1:0] w);
    logic [15:0] p;
    case (w)
      2'd0:    p = 16'd10923;
      2'd1:    p = 16'd32768;
      2'd2:    p = 16'd54613;
      default: p = 16'd0;
    endcase
    return p;
  endfunction

  // Floor of num over the k-th Taylor divisor by reciprocal multiply, one fixup step
  function automatic logic [63:0] taylor_quot(input logic [63:0] num, input int k);
    logic [63:0]  dv;
    logic [63:0]  rc;
    logic [127:0] p;
    logic [63:0]  q;
    case (k)
      1: begin
        dv = TAYLOR_D1;
        rc = TAYLOR_R1;
      end
      2: begin
        dv = TAYLOR_D2;
        rc = TAYLOR_R2;
      end
      3: begin
        dv = TAYLOR_D3;
        rc = TAYLOR_R3;
      end
      4: begin
        dv = TAYLOR_D4;
        rc = TAYLOR_R4;
      end
      5: begin
        dv = TAYLOR_D5;
        rc = TAYLOR_R5;
      end
      6: begin
        dv = TAYLOR_D6;
        rc = TAYLOR_R6;
      end
      default: begin
        dv = TAYLOR_D7;
        rc = TAYLOR_R7;
      end
    endcase
    p = 128'(num) * 128'(rc);
    q = p[127:64];
    if ((num - q * dv) >= dv) q = q + 64'd1;
    return q;
  endfunction

  // One quarter-wave entry in Q0.15, Taylor series in Q2.30
  function automatic logic [14:0] sine_entry(input int i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        r;
    x    = (64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    acc  = $signed(x);
    for (int k = 1; k <= 7; k++) begin
      term = taylor_quot((term * x2) >> 30, k);
      if ((k & 1) == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    if (acc < 0) acc = '0;
    r = ($unsigned(acc) + 64'd16384) >> 15;
    return (r > 64'd32767) ? 15'h7FFF : r[14:0];
  endfunction

  function automatic logic [TAB_N:0][14:0] sine_table();
    logic [TAB_N:0][14:0] t;
    for (int i = 0; i <= TAB_N; i++) begin
      t[i] = sine_entry(i);
    end
    return t;
  endfunction

  localparam logic [TAB_N:0][14:0] SINE_TAB = sine_table();

endpackage

`default_nettype wire

// ===== rtl/omd_regs.sv =====
// APB register file holding gains, clamps and wheel identifiers
`default_nettype none

module omd_regs
  import omd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Update the addressed register, drop writes past the list
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_PROP_GAIN:   cfg_d.prop_gain   = pwdata[15:0];
        REG_DERIV_GAIN:  cfg_d.deriv_gain  = pwdata[15:0];
        REG_SPEED_CLAMP: cfg_d.speed_clamp = pwdata[11:0];
        REG_TURN_CLAMP:  cfg_d.turn_clamp  = pwdata[11:0];
        REG_WHEEL0_ID:   cfg_d.wheel0_id   = pwdata[10:0];
        REG_WHEEL1_ID:   cfg_d.wheel1_id   = pwdata[10:0];
        REG_WHEEL2_ID:   cfg_d.wheel2_id   = pwdata[10:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain   <= 16'sd256;
      cfg_q.deriv_gain  <= 16'sd0;
      cfg_q.speed_clamp <= 12'd100;
      cfg_q.turn_clamp  <= 12'd30;
      cfg_q.wheel0_id   <= 11'd1;
      cfg_q.wheel1_id   <= 11'd2;
      cfg_q.wheel2_id   <= 11'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back raw register bits
  always_comb begin
    case (idx)
      REG_PROP_GAIN:   prdata = {16'b0, cfg_q.prop_gain};
      REG_DERIV_GAIN:  prdata = {16'b0, cfg_q.deriv_gain};
      REG_SPEED_CLAMP: prdata = {20'b0, cfg_q.speed_clamp};
      REG_TURN_CLAMP:  prdata = {20'b0, cfg_q.turn_clamp};
      REG_WHEEL0_ID:   prdata = {21'b0, cfg_q.wheel0_id};
      REG_WHEEL1_ID:   prdata = {21'b0, cfg_q.wheel1_id};
      REG_WHEEL2_ID:   prdata = {21'b0, cfg_q.wheel2_id};
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/omd_ctrl.sv =====
// Sequencer that steps the datapath through the PD term and the three wheels
`default_nettype none

`include "omni_drive_pd_mixer_macros.svh"

module omd_ctrl
  import omd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       stop_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] wheel_q, wheel_d;
  logic       stop_q, stop_d;
  logic       s_accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign s_accept   = in_valid_i && in_ready_o;

  // Next state and datapath strobes
  always_comb begin
    state_d = state_q;
    wheel_d = wheel_q;
    stop_d  = stop_q;
    cmd_o   = '0;
    cmd_o.stop  = stop_q;
    cmd_o.wheel = wheel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          stop_d     = stop_i;
          wheel_d    = 2'd0;
          state_d    = stop_i ? ST_W_EMIT : ST_PD_MUL;
        end
      end
      ST_PD_MUL: begin
        cmd_o.pd_mul = 1'b1;
        state_d      = ST_PD_SUM;
      end
      ST_PD_SUM: begin
        cmd_o.pd_sum = 1'b1;
        state_d      = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_W_MUL;
      end
      ST_W_MUL: begin
        cmd_o.w_mul = 1'b1;
        state_d     = ST_W_SUM;
      end
      ST_W_SUM: begin
        cmd_o.w_sum = 1'b1;
        state_d     = ST_W_EMIT;
      end
      ST_W_EMIT: begin
        // Hold until the output register can take the frame
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (wheel_q == WHEEL_LAST) begin
            state_d = ST_IDLE;
          end else begin
            wheel_d = wheel_q + 2'd1;
            state_d = stop_q ? ST_W_EMIT : ST_W_MUL;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wheel_q <= 2'd0;
      stop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wheel_q <= wheel_d;
      stop_q  <= stop_d;
    end
  end

  `OMD_ASSERT_IMPL(a_wheel_range, 1'b1, wheel_q <= WHEEL_LAST)
  `OMD_ASSERT_NEXT(a_done_idle, cmd_o.emit && (wheel_q == WHEEL_LAST), state_q == ST_IDLE)
  `OMD_ASSERT_NEXT(a_stop_emit, s_accept && stop_i, state_q == ST_W_EMIT)

endmodule

`default_nettype wire

// ===== rtl/omd_dp.sv =====
// Datapath: PD term, sine lookup, clamps, truncation and output frame register
`default_nettype none

`include "omni_drive_pd_mixer_macros.svh"

module omd_dp
  import omd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [IN_DATA_W-1:0] in_data_i,
  input  wire cfg_t                 cfg_i,
  input  wire dp_cmd_t              cmd_i,
  output dp_status_t                status_o,
  output logic                      m_valid_o,
  input  wire logic                 m_ready_i,
  output logic [1:0]                m_wheel_o,
  output logic [10:0]               m_node_id_o,
  output logic [7:0]                m_cmd_o,
  output logic [25:0]               m_power_o,
  output logic                      m_last_o
);

  // Captured command and state
  logic [15:0]        heading_q;
  logic signed [23:0] speed_q;
  logic signed [23:0] rot_q;
  logic signed [23:0] prev_q;

  // Intermediate results
  logic signed [39:0] prod_q;
  logic signed [24:0] diff_q;
  logic signed [41:0] pd_q;
  logic signed [52:0] scaled_q;
  logic signed [39:0] tprod_q;
  logic signed [37:0] sum_q;

  // Output frame
  logic               m_valid_q;
  logic [1:0]         m_wheel_q;
  logic [10:0]        m_node_id_q;
  cmd_code_e          m_cmd_q;
  logic signed [25:0] m_power_q;
  logic               m_last_q;

  // PD products
  logic signed [39:0] prop_prod;
  logic signed [24:0] rot_diff;
  logic signed [40:0] deriv_prod;
  logic signed [41:0] pd_next;
  logic signed [52:0] pd_x;
  logic signed [52:0] scaled_next;

  assign prop_prod   = cfg_i.prop_gain * rot_q;
  assign rot_diff    = 25'(rot_q) - 25'(prev_q);
  assign deriv_prod  = cfg_i.deriv_gain * diff_q;
  assign pd_next     = 42'(prod_q) + 42'(deriv_prod);

  // Times 1631/256 as 2048 - 256 - 128 - 32 - 1
  assign pd_x        = 53'(pd_q);
  assign scaled_next = (pd_x <<< 11) - (pd_x <<< 8) - (pd_x <<< 7) - (pd_x <<< 5) - pd_x;

  // Sine of wheel phase minus heading from the quarter-wave table
  logic [15:0]                 phase_d;
  logic [SINE_TABLE_BITS-1:0]  tab_idx;
  logic [TAB_ADDR_W-1:0]       tab_addr;
  logic [14:0]                 sin_mag;
  logic signed [15:0]          sin_val;
  logic signed [39:0]          tprod_next;

  assign phase_d  = wheel_phase(cmd_i.wheel) - heading_q;
  assign tab_idx  = phase_d[13 -: SINE_TABLE_BITS];
  assign tab_addr = phase_d[14] ? (TAB_ADDR_W'(TAB_N) - {1'b0, tab_idx}) : {1'b0, tab_idx};
  assign sin_mag  = SINE_TAB[tab_addr];
  assign sin_val  = phase_d[15] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
  assign tprod_next = speed_q * sin_val;

  // Clamp both terms and add them in Q.24
  logic signed [40:0] neg_tr;
  logic signed [40:0] tr_lim;
  logic signed [40:0] tr_c;
  logic signed [52:0] rt_lim;
  logic signed [52:0] rt_c;
  logic signed [37:0] sum_next;

  assign neg_tr = -(41'(tprod_q));
  assign tr_lim = $signed({6'b0, cfg_i.speed_clamp, 23'b0});
  assign rt_lim = $signed({17'b0, cfg_i.turn_clamp, 24'b0});

  always_comb begin
    if (neg_tr > tr_lim) tr_c = tr_lim;
    else if (neg_tr < -tr_lim) tr_c = -tr_lim;
    else tr_c = neg_tr;
    if (scaled_q > rt_lim) rt_c = rt_lim;
    else if (scaled_q < -rt_lim) rt_c = -rt_lim;
    else rt_c = scaled_q;
  end

  assign sum_next = (38'(tr_c) <<< 1) + 38'(rt_c);

  // Truncate toward zero, then scale to the wheel value
  logic               round_up;
  logic signed [13:0] wheel_n;
  logic signed [25:0] power_next;

  assign round_up   = sum_q[37] && (sum_q[23:0] != 24'd0);
  assign wheel_n    = $signed(sum_q[37:24]) + $signed({13'b0, round_up});
  assign power_next = 26'(wheel_n) * POWER_SCALE;

  logic [10:0] node_id;
  always_comb begin
    case (cmd_i.wheel)
      2'd0:    node_id = cfg_i.wheel0_id;
      2'd1:    node_id = cfg_i.wheel1_id;
      2'd2:    node_id = cfg_i.wheel2_id;
      default: node_id = '0;
    endcase
  end

  // Previous error and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.pd_mul) prev_q <= rot_q;
      if (cmd_i.emit) m_valid_q <= 1'b1;
      else if (m_ready_i) m_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      heading_q <= in_data_i[15:0];
      speed_q   <= in_data_i[39:16];
      rot_q     <= in_data_i[63:40];
    end
    if (cmd_i.pd_mul) begin
      prod_q <= prop_prod;
      diff_q <= rot_diff;
    end
    if (cmd_i.pd_sum) pd_q <= pd_next;
    if (cmd_i.scale) scaled_q <= scaled_next;
    if (cmd_i.w_mul) tprod_q <= tprod_next;
    if (cmd_i.w_sum) sum_q <= sum_next;
    if (cmd_i.emit) begin
      m_wheel_q   <= cmd_i.wheel;
      m_node_id_q <= node_id;
      m_cmd_q     <= cmd_i.stop ? CMD_STOP : CMD_RUN;
      m_power_q   <= cmd_i.stop ? 26'sd0 : power_next;
      m_last_q    <= (cmd_i.wheel == WHEEL_LAST);
    end
  end

  assign status_o.out_free = !m_valid_q || m_ready_i;
  assign m_valid_o   = m_valid_q;
  assign m_wheel_o   = m_wheel_q;
  assign m_node_id_o = m_node_id_q;
  assign m_cmd_o     = m_cmd_q;
  assign m_power_o   = m_power_q;
  assign m_last_o    = m_last_q;

  `OMD_ASSERT_IMPL(a_last_wheel, m_valid_q, m_last_q == (m_wheel_q == WHEEL_LAST))
  `OMD_ASSERT_IMPL(a_stop_zero, m_valid_q && (m_cmd_q == CMD_STOP), m_power_q == 26'sd0)
  `OMD_ASSERT_NEXT(a_emit_valid, cmd_i.emit, m_valid_q)

endmodule

`default_nettype wire

// ===== rtl/omni_drive_pd_mixer.sv =====
// Top level of the three-wheel omni drive mixer with PD rotation term
//
// Channel   Dir  Bits                                Beat
// s_axis    in   tdata: heading[15:0] travel_speed   one drive or stop command
//                [39:16] turn_error[63:40];
//                tuser: mode[0]
// m_axis    out  tdata: node_id[10:0]                one wheel frame, three per
//                wheel_power[36:11] (pad to 40);      command, tlast on wheel 2
//                tuser: wheel_index[1:0]
//                command_code[9:2]
// apb       in   7 registers at 4*i                  gains, clamps, motor ids
//
// A run command steps from acceptance through the PD term and its 6.37 scale,
// then through each wheel (sine and speed product, clamp and add, truncate and
// times 2390) until its last frame enters the output register.
// A stop command goes straight to the emit step and emits one frame per wheel.
// A new command is accepted once the sequencer is back in idle, even while the
// last frame still waits in the output register; m_axis_tready low holds the
// sequencer at its emit step. Reset clears the sequencer, the configuration, the
// output valid and the previous turn error; nothing needs a clearing pass.
`default_nettype none

module omni_drive_pd_mixer
  import omd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Command stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // heading, travel_speed, turn_error
  input  wire logic [0:0]            s_axis_tuser,   // mode
  // Wheel frame stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // node_id, wheel_power, zero pad
  output logic [OUT_USER_W-1:0]      m_axis_tuser,   // wheel_index, command_code
  output logic                       m_axis_tlast,
  // Configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic [1:0]  out_wheel;
  logic [10:0] out_node_id;
  logic [7:0]  out_cmd;
  logic [25:0] out_power;

  omd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  omd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stop_i     (s_axis_tuser[0]),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  omd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_wheel_o   (out_wheel),
    .m_node_id_o (out_node_id),
    .m_cmd_o     (out_cmd),
    .m_power_o   (out_power),
    .m_last_o    (m_axis_tlast)
  );

  // Pack the frame fields
  assign m_axis_tdata = {3'b0, out_power, out_node_id};
  assign m_axis_tuser = {out_cmd, out_wheel};

endmodule

`default_nettype wire
